// ===== sv/tlptw_pkg.sv =====
// ----------------------------------------------------------------------------
// tlptw_pkg
// Shared types, codes and helpers for the three-level page table walker.
// ----------------------------------------------------------------------------
`default_nettype none

package tlptw_pkg;

  localparam int PA_W        = 56;   // physical address port width
  localparam int MEM_SIZE_W  = 57;   // memory size register width
  localparam int VA_IN_W     = 40;   // virtual address port width
  localparam int VA_W        = 39;   // legal virtual address width
  localparam int ENTRY_W     = 64;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_ADDR_W  = 4;
  localparam int LEVEL_W     = 2;
  localparam int LEVELS      = 3;
  localparam int IDX_W       = 9;
  localparam int PAGE_SHIFT  = 12;
  localparam int DEF_PHYS_ADDR_BITS = 56;

  localparam logic [LEVEL_W-1:0] LEAF_LEVEL = LEVEL_W'(LEVELS - 1);
  localparam logic [IDX_W-1:0]   IDX_MASK   = 9'h1FF;
  localparam logic [MEM_SIZE_W:0] PAGE_BYTES = (MEM_SIZE_W+1)'(4096);

  // Entry bit positions
  localparam int E_VALID   = 0;
  localparam int E_READ    = 1;
  localparam int E_WRITE   = 2;
  localparam int E_EXEC    = 3;
  localparam int E_USER    = 4;
  localparam int E_RSVD_LO = 5;
  localparam int E_RSVD_HI = 11;

  // Register byte addresses
  localparam logic [CFG_ADDR_W-1:0] REG_ROOT     = 4'h0;
  localparam logic [CFG_ADDR_W-1:0] REG_MEM_SIZE = 4'h8;

  typedef enum logic {
    ACT_TRANSLATE = 1'b0,
    ACT_RESPONSE  = 1'b1
  } action_t;

  typedef enum logic {
    RK_READ = 1'b0,
    RK_DONE = 1'b1
  } result_kind_t;

  typedef enum logic [1:0] {
    ACC_READ   = 2'd0,
    ACC_WRITE  = 2'd1,
    ACC_EXEC   = 2'd2,
    ACC_ATOMIC = 2'd3
  } access_kind_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_VIRTUAL = 3'd1,
    ST_BAD_ROOT    = 3'd2,
    ST_NOT_PRESENT = 3'd3,
    ST_MALFORMED   = 3'd4,
    ST_DENIED      = 3'd5,
    ST_PROTOCOL    = 3'd6
  } status_t;

  typedef struct packed {
    result_kind_t      kind;
    logic [PA_W-1:0]   read_address;
    logic [PA_W-1:0]   phys_addr;
    status_t           status;
  } result_t;

  // 9-bit table index for a level; level 3 wraps to level 0
  function automatic logic [IDX_W-1:0] table_index(input logic [VA_W-1:0] va,
                                                   input logic [LEVEL_W-1:0] lvl);
    logic [IDX_W-1:0] idx;
    begin
      case (lvl)
        2'd1:    idx = va[29:21];
        2'd2:    idx = va[20:12];
        default: idx = va[38:30];
      endcase
      return idx & IDX_MASK;
    end
  endfunction

endpackage

`default_nettype wire

// ===== sv/three_level_page_table_walker.sv =====
// ----------------------------------------------------------------------------
// three_level_page_table_walker
// Walks a three-level 4 KiB page table one entry per transaction.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------
//  in       | in_valid  / in_stall       | action, vaddr,
//           |                            | access_kind, user_access,
//           |                            | entry_data, read_ok
//  out      | out_valid / out_stall      | result_kind, read_address,
//           |                            | phys_addr, status
//  cfg      | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
//  One input transaction per cycle while in_stall is low.
//  All checks for a transaction are one compare/add pass into the output
//  register. A skid register behind it absorbs one result under out_stall;
//  in_stall rises only while the skid register is full.
//  Synchronous active-high reset: idle, no walk in flight, config and walk registers zero.
// ----------------------------------------------------------------------------
`default_nettype none

module three_level_page_table_walker
  import tlptw_pkg::*;
#(
  parameter int PHYS_ADDR_BITS = DEF_PHYS_ADDR_BITS
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  // configuration
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [CFG_ADDR_W-1:0]   paddr,
  input  wire logic [CFG_DATA_W-1:0]   pwdata,
  output      logic [CFG_DATA_W-1:0]   prdata,
  output      logic                    pready,
  // input channel
  input  wire logic                    in_valid,
  output      logic                    in_stall,
  input  wire logic                    action,
  input  wire logic [VA_IN_W-1:0]      vaddr,
  input  wire logic [1:0]              access_kind,
  input  wire logic                    user_access,
  input  wire logic [ENTRY_W-1:0]      entry_data,
  input  wire logic                    read_ok,
  // output channel
  output      logic                    out_valid,
  input  wire logic                    out_stall,
  output      logic                    result_kind,
  output      logic [PA_W-1:0]         read_address,
  output      logic [PA_W-1:0]         phys_addr,
  output      logic [2:0]              status
);

  localparam logic [PA_W-1:0] PA_MASK = {PA_W{1'b1}} >> (PA_W - PHYS_ADDR_BITS);
  localparam logic [PA_W-1:0] ENTRY_ADDR_MASK =
    PA_MASK & ~{{(PA_W-PAGE_SHIFT){1'b0}}, {PAGE_SHIFT{1'b1}}};

  // configuration registers
  logic [PA_W-1:0]       root_table_address;
  logic [MEM_SIZE_W-1:0] memory_size;

  // walk state
  logic                  walk_busy, walk_busy_next;
  logic [LEVEL_W-1:0]    walk_level, walk_level_next;
  logic [PA_W-1:0]       current_table, current_table_next;
  logic [VA_W-1:0]       held_vaddr, held_vaddr_next;
  logic [1:0]            held_access_kind, held_access_kind_next;
  logic                  held_user, held_user_next;

  // output register and skid
  result_t               out_res, skid_res, res;
  logic                  skid_valid;

  logic                  in_acc, out_take, cfg_wr;

  assign in_acc   = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign in_stall = skid_valid;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      root_table_address <= '0;
      memory_size        <= '0;
    end else if (cfg_wr) begin
      if (paddr[3] == REG_MEM_SIZE[3]) begin
        memory_size <= pwdata[MEM_SIZE_W-1:0];
      end else begin
        root_table_address <= pwdata[PA_W-1:0] & PA_MASK;
      end
    end
  end

  always_comb begin
    if (paddr[3] == REG_MEM_SIZE[3]) begin
      prdata = {{(CFG_DATA_W-MEM_SIZE_W){1'b0}}, memory_size};
    end else begin
      prdata = {{(CFG_DATA_W-PA_W){1'b0}}, root_table_address};
    end
  end

  // --------------------------------------------------------------------------
  // Walk step
  // --------------------------------------------------------------------------
  logic [PA_W-1:0]       next_table;
  logic                  root_fits, next_fits, next_below, root_aligned;
  logic                  perms_any, perm_ok;
  logic [PA_W-1:0]       sel_table;
  logic [VA_W-1:0]       sel_va;
  logic [LEVEL_W-1:0]    sel_level;
  logic [PA_W-1:0]       slot_address;
  logic [MEM_SIZE_W:0]   mem_ext;

  assign next_table   = entry_data[PA_W-1:0] & ENTRY_ADDR_MASK;
  assign mem_ext      = {1'b0, memory_size};
  // a + 4096 <= size, carried one bit wide so it cannot wrap
  assign root_fits    = ({{(MEM_SIZE_W+1-PA_W){1'b0}}, root_table_address} + PAGE_BYTES)
                        <= mem_ext;
  assign next_fits    = ({{(MEM_SIZE_W+1-PA_W){1'b0}}, next_table} + PAGE_BYTES) <= mem_ext;
  assign next_below   = {{(MEM_SIZE_W-PA_W){1'b0}}, next_table} < memory_size;
  assign root_aligned = root_table_address[PAGE_SHIFT-1:0] == '0;
  assign perms_any    = entry_data[E_READ] || entry_data[E_WRITE] || entry_data[E_EXEC];

  always_comb begin
    perm_ok = 1'b0;
    case (access_kind_t'(held_access_kind))
      ACC_READ:   perm_ok = entry_data[E_READ];
      ACC_WRITE:  perm_ok = entry_data[E_WRITE];
      ACC_EXEC:   perm_ok = entry_data[E_EXEC];
      ACC_ATOMIC: perm_ok = entry_data[E_READ] && entry_data[E_WRITE];
      default:    perm_ok = 1'b0;
    endcase
    if (held_user && !entry_data[E_USER]) begin
      perm_ok = 1'b0;
    end
  end

  // one entry-address adder, shared by the request and the next-level read
  always_comb begin
    if (action == ACT_TRANSLATE) begin
      sel_table = root_table_address;
      sel_va    = vaddr[VA_W-1:0];
      sel_level = '0;
    end else begin
      sel_table = next_table;
      sel_va    = held_vaddr;
      sel_level = walk_level + LEVEL_W'(1);
    end
    slot_address = (sel_table + {{(PA_W-IDX_W-3){1'b0}}, table_index(sel_va, sel_level), 3'b000})
                   & PA_MASK;
  end

  always_comb begin
    walk_busy_next        = walk_busy;
    walk_level_next       = walk_level;
    current_table_next    = current_table;
    held_vaddr_next       = held_vaddr;
    held_access_kind_next = held_access_kind;
    held_user_next        = held_user;
    res.kind              = RK_DONE;
    res.read_address      = '0;
    res.phys_addr         = '0;
    res.status            = ST_OK;

    if (action == ACT_TRANSLATE) begin
      if (walk_busy) begin
        res.status = ST_PROTOCOL;
      end else if (vaddr[VA_IN_W-1]) begin
        res.status = ST_BAD_VIRTUAL;
      end else if (!root_aligned || !root_fits) begin
        res.status = ST_BAD_ROOT;
      end else begin
        walk_busy_next        = 1'b1;
        walk_level_next       = '0;
        current_table_next    = root_table_address;
        held_vaddr_next       = vaddr[VA_W-1:0];
        held_access_kind_next = access_kind;
        held_user_next        = user_access;
        res.kind              = RK_READ;
        res.read_address      = slot_address;
      end
    end else if (!walk_busy) begin
      // response with no walk in flight: state untouched
      res.status = ST_PROTOCOL;
    end else begin
      walk_busy_next  = 1'b0;
      walk_level_next = '0;
      if (!read_ok) begin
        res.status = ST_BAD_ROOT;
      end else if (!entry_data[E_VALID]) begin
        res.status = ST_NOT_PRESENT;
      end else if ((entry_data[E_RSVD_HI:E_RSVD_LO] != '0) ||
                   (entry_data[E_WRITE] && !entry_data[E_READ])) begin
        res.status = ST_MALFORMED;
      end else if (walk_level < LEAF_LEVEL) begin
        if (perms_any || entry_data[E_USER] || !next_fits) begin
          res.status = ST_MALFORMED;
        end else begin
          walk_busy_next     = 1'b1;
          walk_level_next    = walk_level + LEVEL_W'(1);
          current_table_next = next_table;
          res.kind           = RK_READ;
          res.read_address   = slot_address;
        end
      end else if (!perms_any) begin
        res.status = ST_MALFORMED;
      end else if (!perm_ok) begin
        res.status = ST_DENIED;
      end else if (next_below && !next_fits) begin
        res.status = ST_MALFORMED;
      end else begin
        res.phys_addr = next_table |
          {{(PA_W-PAGE_SHIFT){1'b0}}, held_vaddr[PAGE_SHIFT-1:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_busy        <= 1'b0;
      walk_level       <= '0;
      current_table    <= '0;
      held_vaddr       <= '0;
      held_access_kind <= '0;
      held_user        <= 1'b0;
    end else if (in_acc) begin
      walk_busy        <= walk_busy_next;
      walk_level       <= walk_level_next;
      current_table    <= current_table_next;
      held_vaddr       <= held_vaddr_next;
      held_access_kind <= held_access_kind_next;
      held_user        <= held_user_next;
    end
  end

  // --------------------------------------------------------------------------
  // Output register with skid
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        skid_valid <= 1'b0;
      end
    end else if (in_acc) begin
      if (out_valid && !out_take) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        out_res <= skid_res;
      end
    end else if (in_acc) begin
      if (out_valid && !out_take) begin
        skid_res <= res;
      end else begin
        out_res <= res;
      end
    end
  end

  assign result_kind  = out_res.kind;
  assign read_address = out_res.read_address;
  assign phys_addr    = out_res.phys_addr;
  assign status       = out_res.status;

endmodule

`default_nettype wire

// ===== tb/three_level_page_table_walker_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_level_page_table_walker_tb
// Self-checking bench for the page table walker. Directed walks hit each
// fault path, then mostly well-formed random walks (with spoilt entries,
// truncated and surplus transactions mixed in) run under several register
// settings and idle/stall mixes. Every result is checked against an
// in-bench prediction of the walk.
// ----------------------------------------------------------------------------

module three_level_page_table_walker_tb;
  import tlptw_pkg::*;

  typedef struct {
    action_t              act;
    logic [VA_IN_W-1:0]   va;
    access_kind_t         kind;
    logic                 user;
    logic [ENTRY_W-1:0]   entry;
    logic                 rok;
  } walk_item_t;

  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [CFG_DATA_W-1:0] pwdata  = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  logic                  in_valid        = 1'b0;
  logic                  in_stall;
  logic                  action          = 1'b0;
  logic [VA_IN_W-1:0]    vaddr           = '0;
  logic [1:0]            access_kind     = '0;
  logic                  user_access     = 1'b0;
  logic [ENTRY_W-1:0]    entry_data      = '0;
  logic                  read_ok         = 1'b0;

  logic                  out_valid;
  logic                  out_stall       = 1'b0;
  logic                  result_kind;
  logic [PA_W-1:0]       read_address;
  logic [PA_W-1:0]       phys_addr;
  logic [2:0]            status;

  three_level_page_table_walker i_dut (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .action           (action),
    .vaddr            (vaddr),
    .access_kind      (access_kind),
    .user_access      (user_access),
    .entry_data       (entry_data),
    .read_ok          (read_ok),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .result_kind      (result_kind),
    .read_address     (read_address),
    .phys_addr        (phys_addr),
    .status           (status)
  );

  // Walker shadow: register copies and the walk in flight
  logic [PA_W-1:0]       root_cfg   = '0;
  logic [MEM_SIZE_W-1:0] mem_cfg    = '0;
  logic                  walking    = 1'b0;
  logic [LEVEL_W-1:0]    walk_depth = '0;
  logic [PA_W-1:0]       table_base = '0;
  logic [VA_W-1:0]       walk_va    = '0;
  access_kind_t          walk_kind  = ACC_READ;
  logic                  walk_user  = 1'b0;

  walk_item_t walk_items[$];
  result_t    results_due[$];
  walk_item_t offered;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int holds_served   = 0;
  int hold_left      = 0;
  int idle_cycles    = 0;

  int items_queued   = 0;
  int items_accepted = 0;
  int results_seen   = 0;
  int reads_seen     = 0;
  int walks_ok       = 0;
  int faults_seen    = 0;
  int protocol_seen  = 0;
  int errors         = 0;
  int settings_used  = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic logic page_fits(input logic [PA_W-1:0] a);
    logic [MEM_SIZE_W:0] a_w;
    logic [MEM_SIZE_W:0] m_w;
    a_w = {2'b00, a};
    m_w = {1'b0, mem_cfg};
    return (a_w <= m_w) && (m_w - a_w >= PAGE_BYTES);
  endfunction

  function automatic logic table_usable(input logic [PA_W-1:0] a);
    return (a[PAGE_SHIFT-1:0] == '0) && page_fits(a);
  endfunction

  function automatic logic [PA_W-1:0] entry_slot();
    logic [IDX_W-1:0] idx;
    case (walk_depth)
      2'd0:    idx = walk_va[38:30];
      2'd1:    idx = walk_va[29:21];
      default: idx = walk_va[20:12];
    endcase
    return table_base + PA_W'({idx, 3'b000});
  endfunction

  function automatic logic permitted(input logic [ENTRY_W-1:0] e);
    if (walk_user && !e[E_USER]) return 1'b0;
    case (walk_kind)
      ACC_READ:  return e[E_READ];
      ACC_WRITE: return e[E_WRITE];
      ACC_EXEC:  return e[E_EXEC];
      default:   return e[E_READ] && e[E_WRITE];
    endcase
  endfunction

  function automatic result_t next_walk_result(input walk_item_t it);
    result_t         r;
    logic [PA_W-1:0] nxt;
    logic [2:0]      perms;
    r.kind         = RK_DONE;
    r.read_address = '0;
    r.phys_addr    = '0;
    r.status       = ST_OK;
    nxt   = {it.entry[PA_W-1:PAGE_SHIFT], 12'h000};
    perms = it.entry[E_EXEC:E_READ];
    if (it.act == ACT_TRANSLATE) begin
      if (walking) r.status = ST_PROTOCOL;
      else if (it.va[VA_IN_W-1]) r.status = ST_BAD_VIRTUAL;
      else if (!table_usable(root_cfg)) r.status = ST_BAD_ROOT;
      else begin
        walking    = 1'b1;
        walk_depth = '0;
        table_base = root_cfg;
        walk_va    = it.va[VA_W-1:0];
        walk_kind  = it.kind;
        walk_user  = it.user;
        r.kind         = RK_READ;
        r.read_address = entry_slot();
      end
      return r;
    end
    // stray response: walk state untouched
    if (!walking) begin
      r.status = ST_PROTOCOL;
      return r;
    end
    if (!it.rok) r.status = ST_BAD_ROOT;
    else if (!it.entry[E_VALID]) r.status = ST_NOT_PRESENT;
    else if (|it.entry[E_RSVD_HI:E_RSVD_LO] || (it.entry[E_WRITE] && !it.entry[E_READ]))
      r.status = ST_MALFORMED;
    else if (walk_depth < LEAF_LEVEL) begin
      if (perms != '0 || it.entry[E_USER] || !table_usable(nxt)) r.status = ST_MALFORMED;
      else begin
        table_base = nxt;
        walk_depth = walk_depth + LEVEL_W'(1);
        r.kind         = RK_READ;
        r.read_address = entry_slot();
        return r;
      end
    end
    else if (perms == '0) r.status = ST_MALFORMED;
    else if (!permitted(it.entry)) r.status = ST_DENIED;
    else if ({1'b0, nxt} < mem_cfg && !page_fits(nxt)) r.status = ST_MALFORMED;
    else r.phys_addr = {nxt[PA_W-1:PAGE_SHIFT], walk_va[PAGE_SHIFT-1:0]};
    walking    = 1'b0;
    walk_depth = '0;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Input driver
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_walker
    walk_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        results_due.push_back(next_walk_result(offered));
        items_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (walk_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          it = walk_items.pop_front();
          offered     <= it;
          in_valid    <= 1'b1;
          action      <= it.act;
          vaddr       <= it.va;
          access_kind <= it.kind;
          user_access <= it.user;
          entry_data  <= it.entry;
          read_ok     <= it.rok;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input result_t want, input result_t got);
    errors++;
    if (errors <= 10) begin
      $write("%0t: %s: expected kind %0d read %h pa %h status %0d",
             $realtime, what, want.kind, want.read_address, want.phys_addr, want.status);
      $display(", got kind %0d read %h pa %h status %0d",
               got.kind, got.read_address, got.phys_addr, got.status);
    end
  endtask

  always @(posedge clk) begin : watch_results
    result_t got;
    result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.kind         = result_kind_t'(result_kind);
        got.read_address = read_address;
        got.phys_addr    = phys_addr;
        got.status       = status_t'(status);
        results_seen++;
        if (got.kind == RK_READ) reads_seen++;
        else if (got.status == ST_OK) walks_ok++;
        else if (got.status == ST_PROTOCOL) protocol_seen++;
        else faults_seen++;
        if (results_due.size() == 0) begin
          want = '0;
          report_mismatch("unexpected transaction", want, got);
        end else begin
          want = results_due.pop_front();
          if (got.kind !== want.kind || got.read_address !== want.read_address ||
              got.phys_addr !== want.phys_addr || got.status !== want.status)
            report_mismatch("mismatch", want, got);
        end
      end
      out_stall <= (hold_left > 0) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // long receiver hold-off so the walker backs up into its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_requests != holds_served) begin
      hold_left    <= HOLD_CYCLES;
      holds_served <= hold_requests;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (walk_items.size() > 0 || in_valid || results_due.size() > 0) begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
               STALL_LIMIT, results_due.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // page number of a table that fits in backed memory, if a page fits at all
  function automatic logic [43:0] fit_page();
    logic [MEM_SIZE_W-1:0] pages;
    pages = mem_cfg >> PAGE_SHIFT;
    if (pages > (57'h1 << 44)) pages = 57'h1 << 44;
    if (pages == '0) return 44'(rand64());
    return 44'(rand64() % pages);
  endfunction

  function automatic logic [63:0] ptr_entry(input logic [PA_W-1:0] a);
    return {8'h00, a[PA_W-1:PAGE_SHIFT], 12'h001};
  endfunction

  function automatic logic [63:0] table_entry();
    logic [63:0] r;
    r = rand64();
    return {r[63:56], fit_page(), 12'h001};
  endfunction

  function automatic logic [63:0] leaf_entry();
    logic [63:0] r;
    logic [2:0]  perms;
    logic [43:0] page;
    r     = rand64();
    perms = 3'($urandom_range(1, 7));  // {X, W, R}
    if (perms[1] && !perms[0]) perms[0] = 1'b1;
    page  = $urandom_range(1) ? fit_page() : r[55:12];
    return {r[63:56], page, 7'h00, r[4], perms, 1'b1};
  endfunction

  task automatic add_item(input action_t act, input logic [VA_IN_W-1:0] va,
                          input access_kind_t kind, input logic user,
                          input logic [ENTRY_W-1:0] e, input logic ok);
    walk_item_t it;
    it.act   = act;
    it.va    = va;
    it.kind  = kind;
    it.user  = user;
    it.entry = e;
    it.rok   = ok;
    walk_items.push_back(it);
    items_queued++;
  endtask

  task automatic send_translate(input logic [VA_IN_W-1:0] va, input access_kind_t kind,
                                input logic user);
    add_item(ACT_TRANSLATE, va, kind, user, rand64(), 1'($urandom_range(1)));
  endtask

  task automatic send_entry(input logic [ENTRY_W-1:0] e, input logic ok);
    add_item(ACT_RESPONSE, 40'(rand64()), access_kind_t'($urandom_range(3)),
             1'($urandom_range(1)), e, ok);
  endtask

  task automatic random_translate();
    send_translate({1'b0, 39'(rand64())}, access_kind_t'($urandom_range(3)),
                   1'($urandom_range(1)));
  endtask

  // full walk; now and then one of the three entries is spoilt
  task automatic queue_walk();
    int          spoil;
    logic [63:0] e;
    logic        ok;
    spoil = ($urandom_range(99) < 25) ? $urandom_range(1, 3) : 0;
    random_translate();
    for (int lvl = 1; lvl <= 3; lvl++) begin
      e  = (lvl < 3) ? table_entry() : leaf_entry();
      ok = 1'b1;
      if (spoil == lvl) begin
        case ($urandom_range(2))
          0:       e = rand64();
          1:       ok = 1'b0;
          default: e = e ^ (64'h1 << $urandom_range(11));
        endcase
      end
      send_entry(e, ok);
    end
  endtask

  task automatic queue_broken();
    case ($urandom_range(2))
      0: begin
        random_translate();
        repeat ($urandom_range(2)) send_entry(table_entry(), 1'b1);
      end
      1: begin
        queue_walk();
        send_entry(table_entry(), 1'b1);
      end
      default: begin
        random_translate();
        random_translate();
      end
    endcase
  endtask

  task automatic random_items(input int n);
    int goal;
    int pick;
    goal = items_queued + n;
    while (items_queued < goal) begin
      pick = $urandom_range(99);
      if (pick < 70) queue_walk();
      else if (pick < 85)
        add_item(action_t'($urandom_range(1)), 40'(rand64()), access_kind_t'($urandom_range(3)),
                 1'($urandom_range(1)), rand64(), 1'($urandom_range(1)));
      else queue_broken();
    end
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == REG_ROOT) root_cfg = data[PA_W-1:0];
    else mem_cfg = data[MEM_SIZE_W-1:0];
  endtask

  task automatic settle();
    while (walk_items.size() > 0 || in_valid || results_due.size() > 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic configure(input logic [63:0] root, input logic [63:0] mem,
                           input int idle_pct, input int stall_pct);
    settle();
    cfg_write(REG_ROOT, root);
    cfg_write(REG_MEM_SIZE, mem);
    @(negedge clk);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    settings_used++;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: memory end is not page aligned so a partial leaf page exists
    configure(64'h1000, 64'h10_0800, 0, 0);
    send_entry(ptr_entry(56'h2000), 1'b1);            // no walk open
    send_translate(40'hFF_FFFF_FFFF, ACC_ATOMIC, 1'b1);
    send_translate(40'h0, ACC_READ, 1'b0);
    send_entry(ptr_entry(56'h2000), 1'b1);
    send_translate(40'h12_3456_7000, ACC_WRITE, 1'b0); // busy, walk kept
    send_entry(ptr_entry(56'hF_F000), 1'b1);          // last table that fits
    send_entry(64'hFF00_0000_0000_501F, 1'b1);
    send_translate(40'h7F_FFFF_FFFF, ACC_WRITE, 1'b0);
    send_entry(ptr_entry(56'h2000), 1'b0);
    send_translate(40'h7F_FFFF_FFFF, ACC_READ, 1'b0);
    send_entry(64'hFFFF_FFFF_FFFF_FFFE, 1'b1);
    send_translate(40'h00_4020_1000, ACC_READ, 1'b0);
    send_entry(ptr_entry(56'h2000) | 64'h20, 1'b1);   // reserved bit
    send_translate(40'h00_4020_1000, ACC_READ, 1'b0);
    send_entry(64'h2005, 1'b1);                       // W without R
    send_translate(40'h00_4020_1000, ACC_READ, 1'b0);
    send_entry(ptr_entry(56'h2000) | 64'h10, 1'b1);   // U on a pointer
    send_translate(40'h00_4020_1000, ACC_READ, 1'b0);
    send_entry(ptr_entry(56'h10_0000), 1'b1);         // next table past the end
    send_translate(40'h40_2010_0ABC, ACC_EXEC, 1'b1);
    send_entry(ptr_entry(56'h2000), 1'b1);
    send_entry(ptr_entry(56'h3000), 1'b1);
    send_entry(64'h3009, 1'b1);                       // X leaf, no U
    send_translate(40'h40_2010_0ABC, ACC_READ, 1'b0);
    send_entry(ptr_entry(56'h2000), 1'b1);
    send_entry(ptr_entry(56'h3000), 1'b1);
    send_entry(64'h4011, 1'b1);                       // leaf with no permissions
    send_translate(40'h40_2010_0ABC, ACC_WRITE, 1'b0);
    send_entry(ptr_entry(56'h2000), 1'b1);
    send_entry(ptr_entry(56'h3000), 1'b1);
    send_entry(64'h10_0007, 1'b1);                    // leaf page cut by memory end

    configure({52'($urandom_range(511)), 12'h000}, 64'h20_0000 + $urandom_range(4095), 0, 0);
    hold_requests++;
    random_items(220);

    configure(64'hFFFF_FFFF_FFFF_F000, 64'hFFFF_FFFF_FFFF_FFFF, 64, 0);
    random_items(220);

    configure(64'h0, 64'h1000, 0, 64);
    random_items(220);

    configure({8'h00, 44'(rand64()), 12'h000}, 64'h0100_0000_0000_0000, 12, 12);
    random_items(220);

    configure(64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 12, 12);
    random_items(40);

    configure(64'h7000, 64'h9000, 12, 12);
    random_items(200);

    settle();
    repeat (16) @(negedge clk);
    $display("Covered %0d input transactions and %0d results over %0d register settings",
             items_accepted, results_seen, settings_used);
    $display("  %0d entry reads, %0d translations, %0d faults, %0d protocol errors, %0d bad",
             reads_seen, walks_ok, faults_seen, protocol_seen, errors);
    if (errors == 0 && results_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
